FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication: trigger now, consequence on the next edge
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lr_pkg.sv
package lr_pkg;

    localparam int COORD_W = 10;
    localparam int ERR_W   = 12;

    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0]      cur_x;
        logic [COORD_W-1:0]      cur_y;
        logic [COORD_W-1:0]      tgt_x;
        logic [COORD_W-1:0]      tgt_y;
        logic                    neg_x;
        logic                    neg_y;
        logic [COORD_W-1:0]      span_x;
        logic [COORD_W-1:0]      span_y;
        logic signed [ERR_W-1:0] err;
        logic                    active;
    } line_state_t;

endpackage

FILE: src/lr_setup.sv
module lr_setup #(
    parameter int SCREEN_WIDTH  = lr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = lr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic [lr_pkg::COORD_W-1:0] start_x,
    input  logic [lr_pkg::COORD_W-1:0] start_y,
    input  logic [lr_pkg::COORD_W-1:0] end_x,
    input  logic [lr_pkg::COORD_W-1:0] end_y,
    output lr_pkg::line_state_t        line_init
);

    localparam int MAX_X = SCREEN_WIDTH - 1;
    localparam int MAX_Y = SCREEN_HEIGHT - 1;

    function automatic logic [lr_pkg::COORD_W-1:0] clamp_coord(
        input logic [lr_pkg::COORD_W-1:0] v,
        input int                         max_c
    );
        if (int'(v) > max_c)
            return lr_pkg::COORD_W'(max_c);
        return v;
    endfunction

    logic [lr_pkg::COORD_W-1:0] sx, sy, ex, ey;
    logic [lr_pkg::COORD_W-1:0] span_x, span_y, major, minor;
    logic                       neg_x, neg_y, col_major;

    always_comb
    begin
        sx = clamp_coord(start_x, MAX_X);
        sy = clamp_coord(start_y, MAX_Y);
        ex = clamp_coord(end_x, MAX_X);
        ey = clamp_coord(end_y, MAX_Y);

        neg_x  = ex < sx;
        neg_y  = ey < sy;
        span_x = neg_x ? sx - ex : ex - sx;
        span_y = neg_y ? sy - ey : ey - sy;

        // equal spans step along rows
        col_major = span_y < span_x;
        major     = col_major ? span_x : span_y;
        minor     = col_major ? span_y : span_x;

        line_init.cur_x  = sx;
        line_init.cur_y  = sy;
        line_init.tgt_x  = ex;
        line_init.tgt_y  = ey;
        line_init.neg_x  = neg_x;
        line_init.neg_y  = neg_y;
        line_init.span_x = span_x;
        line_init.span_y = span_y;
        line_init.err    = lr_pkg::ERR_W'({minor, 1'b0}) - lr_pkg::ERR_W'(major);
        line_init.active = 1'b1;
    end

endmodule

FILE: src/lr_step.sv
module lr_step (
    input  lr_pkg::line_state_t        line_cur,
    output logic [lr_pkg::COORD_W-1:0] pix_x,
    output logic [lr_pkg::COORD_W-1:0] pix_y,
    output logic                       pix_last,
    output lr_pkg::line_state_t        line_next
);

    logic                       col_major, minor_step;
    logic [lr_pkg::COORD_W-1:0] major, minor;
    logic [lr_pkg::COORD_W-1:0] x_step, y_step;

    always_comb
    begin
        col_major  = line_cur.span_y < line_cur.span_x;
        major      = col_major ? line_cur.span_x : line_cur.span_y;
        minor      = col_major ? line_cur.span_y : line_cur.span_x;
        pix_last   = col_major ? (line_cur.cur_x == line_cur.tgt_x)
                               : (line_cur.cur_y == line_cur.tgt_y);
        pix_x      = line_cur.cur_x;
        pix_y      = line_cur.cur_y;
        minor_step = line_cur.err > 0;

        x_step = line_cur.neg_x ? line_cur.cur_x - 1'b1 : line_cur.cur_x + 1'b1;
        y_step = line_cur.neg_y ? line_cur.cur_y - 1'b1 : line_cur.cur_y + 1'b1;

        line_next = line_cur;
        if (pix_last)
        begin
            line_next.active = 1'b0;
        end
        else
        begin
            if (col_major || minor_step)
                line_next.cur_x = x_step;
            if (!col_major || minor_step)
                line_next.cur_y = y_step;
            if (minor_step)
                line_next.err = line_cur.err + lr_pkg::ERR_W'({minor, 1'b0})
                                - lr_pkg::ERR_W'({major, 1'b0});
            else
                line_next.err = line_cur.err + lr_pkg::ERR_W'({minor, 1'b0});
        end
    end

endmodule

FILE: src/line_rasterizer_unit.sv
// channel | signals                                  | word
// in      | in_valid, in_ready                       | cmd, start_x, start_y, end_x, end_y
// out     | out_valid, out_ready                     | pixel_x, pixel_y, last_pixel
//
// one word per clock on the input while in_ready is high; an advance of an active line
// gives its pixel in the next cycle through the output register
// line state and output register clear on rst_n low, no line active after reset
// in_ready drops only while the output register holds a pixel that is not taken
// the step logic (one add and compare on the decision term) is combinational and adds no stall
module line_rasterizer_unit #(
    parameter int SCREEN_WIDTH  = lr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = lr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [lr_pkg::COORD_W-1:0] start_x,
    input  logic [lr_pkg::COORD_W-1:0] start_y,
    input  logic [lr_pkg::COORD_W-1:0] end_x,
    input  logic [lr_pkg::COORD_W-1:0] end_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [lr_pkg::COORD_W-1:0] pixel_x,
    output logic [lr_pkg::COORD_W-1:0] pixel_y,
    output logic                       last_pixel
);

`include "assert_macros.svh"

    lr_pkg::line_state_t        state_reg, state_next;
    lr_pkg::line_state_t        line_init, line_step;
    logic [lr_pkg::COORD_W-1:0] step_x, step_y;
    logic                       step_last;
    logic                       accept, load, advance;
    logic                       out_valid_reg, out_valid_next;
    logic [lr_pkg::COORD_W-1:0] pix_x_reg, pix_y_reg;
    logic                       last_reg;

    lr_setup #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_setup (
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .line_init (line_init)
    );

    lr_step u_step (
        .line_cur  (state_reg),
        .pix_x     (step_x),
        .pix_y     (step_y),
        .pix_last  (step_last),
        .line_next (line_step)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign load     = accept && (cmd == lr_pkg::CMD_START);
    assign advance  = accept && (cmd == lr_pkg::CMD_ADVANCE) && state_reg.active;

    always_comb
    begin
        state_next = state_reg;
        if (load)
            state_next = line_init;
        else if (advance)
            state_next = line_step;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output word, loaded only when a pixel is produced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_x_reg <= '0;
            pix_y_reg <= '0;
            last_reg  <= 1'b0;
        end
        else if (advance)
        begin
            pix_x_reg <= step_x;
            pix_y_reg <= step_y;
            last_reg  <= step_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pix_x_reg;
    assign pixel_y    = pix_y_reg;
    assign last_pixel = last_reg;

    `ASSERT_NEXT(a_last_ends_line, advance && step_last, !state_reg.active && out_valid, "last pixel did not end the line")
    `ASSERT_NEXT(a_load_arms_line, load, state_reg.active, "start word did not arm a line")
    `ASSERT_CLK(a_err_in_range, !state_reg.active || ((state_reg.err > -12'sd2047) && (state_reg.err < 12'sd2047)), "decision term out of range")
    `ASSERT_NEXT(a_no_pixel_on_idle, accept && !advance && !out_ready, out_valid == $past(out_valid_reg), "output changed without a pixel")

endmodule

FILE: tb/tb_line_rasterizer_unit.sv
module tb_line_rasterizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = lr_pkg::COORD_W;
    localparam int SCR_W       = lr_pkg::SCREEN_WIDTH_DEF;
    localparam int SCR_H       = lr_pkg::SCREEN_HEIGHT_DEF;
    localparam logic ST        = lr_pkg::CMD_START;
    localparam logic AD        = lr_pkg::CMD_ADVANCE;
    localparam int RANDOM_WORDS = 1350;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } pixel_t;

    // one directed word; typed rows carry the pixel read straight off the spec
    typedef struct packed {
        logic          c;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        bit            typed;
        bit            some;
        pixel_t        pix;
    } dir_row_t;

    typedef logic signed [lr_pkg::ERR_W-1:0] err_t;

    localparam pixel_t NOPIX = '0;

    logic          clk        = 1'b0;
    logic          rst_n      = 1'b0;
    logic          in_valid   = 1'b0;
    logic          in_ready;
    logic          cmd        = 1'b0;
    logic [CW-1:0] start_x    = '0;
    logic [CW-1:0] start_y    = '0;
    logic [CW-1:0] end_x      = '0;
    logic [CW-1:0] end_y      = '0;
    logic          out_valid;
    logic          out_ready  = 1'b0;
    logic [CW-1:0] pixel_x;
    logic [CW-1:0] pixel_y;
    logic          last_pixel;

    // typed expectation that travels with the word on the input
    bit            word_typed = 1'b0;
    bit            word_some  = 1'b0;
    pixel_t        word_pix   = '0;

    lr_pkg::line_state_t line_st;
    pixel_t        expected_pixels[$];
    int            fail_count     = 0;
    int            pixels_checked = 0;
    int            lines_loaded   = 0;
    int            ignored_words  = 0;
    int            words_sent     = 0;
    bit            no_idle        = 1'b0;
    bit            hold_req       = 1'b0;
    bit            hold_done      = 1'b0;
    int            hold_left      = 0;
    int            quiet_cycles   = 0;

    line_rasterizer_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [CW-1:0] screen_clamp(logic [CW-1:0] v, int limit);
        return (int'(v) > limit - 1) ? CW'(limit - 1) : v;
    endfunction

    function automatic logic [CW-1:0] step_toward(logic [CW-1:0] v, logic negative);
        return negative ? v - 1'b1 : v + 1'b1;
    endfunction

    // advances the line state by one accepted word
    task automatic rasterize_word(input logic c, input logic [CW-1:0] sx, sy, ex, ey,
                                  output bit produced, output pixel_t pix);
        logic [CW-1:0] cx, cy, tx, ty;
        int            major, minor, err_i;
        bit            col_major, at_end;
        produced = 1'b0;
        pix      = '0;
        if (c == ST)
        begin
            cx = screen_clamp(sx, SCR_W);
            cy = screen_clamp(sy, SCR_H);
            tx = screen_clamp(ex, SCR_W);
            ty = screen_clamp(ey, SCR_H);
            line_st.cur_x  = cx;
            line_st.cur_y  = cy;
            line_st.tgt_x  = tx;
            line_st.tgt_y  = ty;
            line_st.neg_x  = tx < cx;
            line_st.neg_y  = ty < cy;
            line_st.span_x = line_st.neg_x ? cx - tx : tx - cx;
            line_st.span_y = line_st.neg_y ? cy - ty : ty - cy;
            col_major = line_st.span_y < line_st.span_x;
            major = col_major ? int'(line_st.span_x) : int'(line_st.span_y);
            minor = col_major ? int'(line_st.span_y) : int'(line_st.span_x);
            line_st.err    = err_t'(2 * minor - major);
            line_st.active = 1'b1;
        end
        else if (line_st.active)
        begin
            col_major = line_st.span_y < line_st.span_x;
            major = col_major ? int'(line_st.span_x) : int'(line_st.span_y);
            minor = col_major ? int'(line_st.span_y) : int'(line_st.span_x);
            at_end = col_major ? (line_st.cur_x == line_st.tgt_x)
                               : (line_st.cur_y == line_st.tgt_y);
            produced = 1'b1;
            pix.x    = line_st.cur_x;
            pix.y    = line_st.cur_y;
            pix.last = at_end;
            if (at_end)
                line_st.active = 1'b0;
            else
            begin
                err_i = $signed(line_st.err);
                if (col_major)
                    line_st.cur_x = step_toward(line_st.cur_x, line_st.neg_x);
                else
                    line_st.cur_y = step_toward(line_st.cur_y, line_st.neg_y);
                if (err_i > 0)
                begin
                    if (col_major)
                        line_st.cur_y = step_toward(line_st.cur_y, line_st.neg_y);
                    else
                        line_st.cur_x = step_toward(line_st.cur_x, line_st.neg_x);
                    line_st.err = err_t'(err_i + 2 * (minor - major));
                end
                else
                    line_st.err = err_t'(err_i + 2 * minor);
            end
        end
    endtask

    task automatic send_word(input logic c, input logic [CW-1:0] sx, sy, ex, ey,
                             input bit typed, input bit some, input pixel_t pix);
        while (!no_idle && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        start_x    <= sx;
        start_y    <= sy;
        end_x      <= ex;
        end_y      <= ey;
        word_typed <= typed;
        word_some  <= some;
        word_pix   <= pix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // checker and predictor, both sampled on the rising edge
    always @(posedge clk)
    begin
        bit     produced;
        pixel_t pred, got, want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{x: pixel_x, y: pixel_y, last: last_pixel};
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel x=%0d y=%0d last=%0b",
                             $time, got.x, got.y, got.last);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (got.x !== want.x)
                    begin
                        $display("%0t: pixel_x expected %0d got %0d", $time, want.x, got.x);
                        fail_count++;
                    end
                    if (got.y !== want.y)
                    begin
                        $display("%0t: pixel_y expected %0d got %0d", $time, want.y, got.y);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t: last_pixel expected %0b got %0b",
                                 $time, want.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                rasterize_word(cmd, start_x, start_y, end_x, end_y, produced, pred);
                if (cmd == ST)
                    lines_loaded++;
                else if (!produced)
                    ignored_words++;
                if (word_typed)
                begin
                    if (word_some)
                        expected_pixels.push_back(word_pix);
                end
                else if (produced)
                    expected_pixels.push_back(pred);
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= no_idle || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("line_rasterizer_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        dir_row_t      dir_rows [23];
        int            rand_words;
        int            nadv;
        int            major;
        int            off;
        bit            far;
        logic [CW-1:0] sx, sy, ex, ey;
        line_st = '0;
        dir_rows = '{
            // advance right after reset: no line yet
            '{AD, 10'd1023, 10'd767, 10'd1023, 10'd767, 1'b1, 1'b0, NOPIX},
            // single-point line
            '{ST, 10'd5, 10'd7, 10'd5, 10'd7, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b1, '{10'd5, 10'd7, 1'b1}},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b0, NOPIX},
            // off-screen row saturates
            '{ST, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b1, '{10'd1023, 10'd767, 1'b1}},
            // corner to corner, dropped after a few pixels
            '{ST, 10'd0, 10'd0, 10'd1023, 10'd1023, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b1, '{10'd0, 10'd0, 1'b0}},
            '{AD, 10'd3, 10'd3, 10'd3, 10'd3, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            // restart while active, equal spans
            '{ST, 10'd10, 10'd10, 10'd7, 10'd13, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            // column major, stepping left and down
            '{ST, 10'd20, 10'd5, 10'd14, 10'd7, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX},
            '{AD, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, NOPIX}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].c, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
                      dir_rows[i].ey, dir_rows[i].typed, dir_rows[i].some, dir_rows[i].pix);

        rand_words = 0;
        while (rand_words < RANDOM_WORDS)
        begin
            no_idle = (rand_words >= 300 && rand_words < 600);
            sx = CW'($urandom_range(0, 1023));
            sy = ($urandom_range(0, 3) == 0) ? CW'($urandom_range(0, 1023))
                                              : CW'($urandom_range(0, SCR_H - 1));
            far = ($urandom_range(0, 4) == 0);
            if (far)
            begin
                ex = CW'($urandom_range(0, 1023));
                ey = CW'($urandom_range(0, 1023));
            end
            else
            begin
                off = $urandom_range(0, 24) - 12;
                ex = CW'((int'(sx) + off < 0) ? 0 : (int'(sx) + off > 1023) ? 1023
                                                   : int'(sx) + off);
                off = $urandom_range(0, 24) - 12;
                ey = CW'((int'(sy) + off < 0) ? 0 : (int'(sy) + off > 1023) ? 1023
                                                   : int'(sy) + off);
            end
            major = int'(screen_clamp(ex, SCR_W)) - int'(screen_clamp(sx, SCR_W));
            if (major < 0)
                major = -major;
            off = int'(screen_clamp(ey, SCR_H)) - int'(screen_clamp(sy, SCR_H));
            if (off < 0)
                off = -off;
            if (off > major)
                major = off;
            if (far)
                nadv = $urandom_range(1, 40);
            else if ($urandom_range(0, 4) == 0)
                nadv = $urandom_range(0, major);
            else
                nadv = major + 1 + $urandom_range(0, 2);

            send_word(ST, sx, sy, ex, ey, 1'b0, 1'b0, NOPIX);
            rand_words++;
            // hold the receiver off while a line keeps the input busy
            if (!hold_req && rand_words > 700 && nadv >= 4)
                hold_req = 1'b1;
            repeat (nadv)
            begin
                send_word(AD, CW'($urandom_range(0, 1023)), CW'($urandom_range(0, 1023)),
                          CW'($urandom_range(0, 1023)), CW'($urandom_range(0, 1023)),
                          1'b0, 1'b0, NOPIX);
                rand_words++;
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $display("%0t: %0d pixels never arrived", $time, expected_pixels.size());
            fail_count++;
        end

        $display("sent %0d words: %0d lines loaded, %0d advances ignored while idle",
                 words_sent, lines_loaded, ignored_words);
        $display("checked %0d pixels, %0d mismatches", pixels_checked, fail_count);
        if (fail_count == 0)
            $display("line_rasterizer_unit regression: pass");
        else
            $display("line_rasterizer_unit regression: fail");
        $finish;
    end

endmodule

FILE: line_rasterizer_unit.f
+incdir+src
src/lr_pkg.sv
src/lr_setup.sv
src/lr_step.sv
src/line_rasterizer_unit.sv
tb/tb_line_rasterizer_unit.sv
